// ----- rtl/ompd_pkg.sv -----
// Shared constants, codes and types for the occupancy map min-pooling downscaler.
package ompd_pkg;

  // Sizing of the line store and the block counters.
  localparam int OUT_WIDTH_MAX = 1024;
  localparam int ADDR_W        = $clog2(OUT_WIDTH_MAX);
  localparam int OCOL_W        = $clog2(OUT_WIDTH_MAX + 1);
  localparam int BLOCK_MAX     = 16;
  localparam int MAG_W         = 5;
  localparam int BIDX_W        = $clog2(BLOCK_MAX);
  localparam int MAP_LIMIT     = 16384;
  localparam int MAP_W         = 15;
  localparam int CELL_W        = 14;
  localparam int OROW_W        = 15;

  // Payload widths.
  localparam int COLOR_W = 16;
  localparam int PIX_X_W = 10;
  localparam int PIX_Y_W = 14;
  localparam int CODE_W  = 8;

  // Output queue: three slots, indexed 0 to 2.
  localparam logic [1:0] OUTQ_LAST_SLOT = 2'd2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_UNKNOWN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_FREE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_OCCUPIED = 3'd5;

  localparam logic [MAG_W-1:0]   RST_BLOCK_SIZE     = 5'd8;
  localparam logic [MAP_W-1:0]   RST_MAP_WIDTH      = 15'd1024;
  localparam logic [MAP_W-1:0]   RST_MAP_HEIGHT     = 15'd1024;
  localparam logic [COLOR_W-1:0] RST_COLOR_UNKNOWN  = 16'd65535;
  localparam logic [COLOR_W-1:0] RST_COLOR_FREE     = 16'd50712;
  localparam logic [COLOR_W-1:0] RST_COLOR_OCCUPIED = 16'd0;

  // Occupancy codes.
  localparam logic signed [CODE_W-1:0] CELL_UNKNOWN  = -8'sd1;
  localparam logic signed [CODE_W-1:0] CELL_FREE     = 8'sd0;
  localparam logic signed [CODE_W-1:0] CELL_OCCUPIED = 8'sd1;

  // One finished pixel as it sits in the output queue.
  typedef struct packed {
    logic [COLOR_W-1:0] pixel;
    logic [PIX_X_W-1:0] x;
    logic [PIX_Y_W-1:0] y;
    logic               last;
  } out_item_t;

  // Work handed from the accept stage to the merge stage.
  typedef struct packed {
    logic               wr;
    logic               emit;
    logic               use_store;
    logic               fwd;
    logic [COLOR_W-1:0] fwd_data;
    logic [COLOR_W-1:0] partial;
    logic [ADDR_W-1:0]  addr;
    logic [PIX_Y_W-1:0] y;
    logic               last;
  } stage_t;

endpackage

// ----- rtl/ompd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ompd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ompd_div.sv -----
// Restoring divider, one quotient bit per cycle, for the output image size.
module ompd_div
  import ompd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAP_W-1:0] dividend,
  input  logic [MAG_W-1:0] divisor,
  output logic             busy,
  output logic [MAP_W-1:0] quotient
);

  logic [MAG_W-1:0]         rem;
  logic [MAG_W-1:0]         dsr;
  logic [$clog2(MAP_W)-1:0] cnt;
  logic [MAG_W-1:0]         trial;
  logic                     ge;

  // The remainder stays below the divisor (at most 16), so four bits shift up.
  assign trial = {rem[MAG_W-2:0], quotient[MAP_W-1]};
  assign ge    = (trial >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ($clog2(MAP_W))'(MAP_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      rem      <= ge ? (trial - dsr) : trial;
      quotient <= {quotient[MAP_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/ompd_fifo.sv -----
// Three-entry output queue of finished pixels.
module ompd_fifo
  import ompd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_item,
  input  logic      pop,
  output logic      head_valid,
  output out_item_t head_item,
  output logic [1:0] count
);

  out_item_t  slots [3];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic       do_pop;

  assign head_valid = (count != 2'd0);
  assign head_item  = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == OUTQ_LAST_SLOT) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == OUTQ_LAST_SLOT) ? 2'd0 : rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // A full queue never takes a pixel unless one leaves in the same cycle.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !do_pop && count == 2'd3))
    else $error("output queue overflow");

  // A push on its own grows the queue by one entry.
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> (count == $past(count) + 2'd1))
    else $error("output queue count did not grow on a push");

  // A pop on its own shrinks the queue by one entry.
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("output queue count did not shrink on a pop");

endmodule

// ----- rtl/occupancy_map_min_pool_downscale.sv -----
// Top level of the occupancy map min-pooling downscaler.
// The block takes one occupancy cell per clock in raster order, maps it to a configured RGB565
// colour and keeps the minimum colour over every block_size by block_size square; when the
// last cell of a square arrives it produces one downscaled pixel with its coordinates, and
// frame_last marks the final pixel of the frame. Cells of partial squares at the right or
// bottom edge are dropped, and codes other than unknown, free and occupied count as a position
// but leave the minimum alone. Sustained rate is one cell per clock while in_stall is low: the cell
// is folded into a running minimum as it is accepted, and the next cycle merges it with the
// per-column minimum held in a 1024-entry line store, writing the merged value back. A pixel
// leaves through a three-entry output queue, so the input keeps flowing while a result waits
// on out_stall. The output image size is found by a bit-serial divider, so after reset and
// after every write to block_size, map_width or map_height the input is stalled until the
// divider is done; configuration writes are always taken.
module occupancy_map_min_pool_downscale
  import ompd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  // Cell input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [CODE_W-1:0]     cell_req,
  // Pixel output channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COLOR_W-1:0]           pixel,
  output logic [PIX_X_W-1:0]           pixel_x,
  output logic [PIX_Y_W-1:0]           pixel_y,
  output logic                         frame_last
);

  // Configuration registers.
  logic [MAG_W-1:0]   block_size;
  logic [MAP_W-1:0]   map_width;
  logic [MAP_W-1:0]   map_height;
  logic [COLOR_W-1:0] color_unknown;
  logic [COLOR_W-1:0] color_free;
  logic [COLOR_W-1:0] color_occupied;

  // Position and block state.
  logic [COLOR_W-1:0] run_min;
  logic [CELL_W-1:0]  cell_col;
  logic [CELL_W-1:0]  cell_row;
  logic [BIDX_W-1:0]  col_in_blk;
  logic [BIDX_W-1:0]  row_in_blk;
  logic [OCOL_W-1:0]  out_col;
  logic [OROW_W-1:0]  out_row;

  // Merge stage.
  logic   s1_valid;
  stage_t s1_q;
  stage_t s1_next;

  // Derived sizes.
  logic [MAG_W-1:0]  mag;
  logic [BIDX_W-1:0] mag_m1;
  logic [MAP_W-1:0]  w_c;
  logic [MAP_W-1:0]  h_c;
  logic [CELL_W-1:0] w_m1;
  logic [CELL_W-1:0] h_m1;
  logic [MAP_W-1:0]  cols_q;
  logic [MAP_W-1:0]  rows_q;
  logic [OCOL_W-1:0] cols_lim;
  logic              div_go;
  logic              busy_c;
  logic              busy_r;

  // Per-cell decisions.
  logic               in_accept;
  logic               cfg_write;
  logic               last_col;
  logic               last_row;
  logic               row_end;
  logic               frame_end;
  logic               in_range;
  logic               known;
  logic [COLOR_W-1:0] cell_color;
  logic [COLOR_W-1:0] run_upd;

  // Line store and output queue.
  logic [COLOR_W-1:0] ram_rdata;
  logic [COLOR_W-1:0] store_val;
  logic [COLOR_W-1:0] merged;
  logic               ram_we;
  out_item_t          push_item;
  out_item_t          head_item;
  logic               push;
  logic               pop;
  logic [1:0]         q_count;
  logic [2:0]         q_demand;

  // ------------------------------------------------------------------
  // Configuration. Writes beyond the register list are taken and ignored.
  // ------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size     <= RST_BLOCK_SIZE;
      map_width      <= RST_MAP_WIDTH;
      map_height     <= RST_MAP_HEIGHT;
      color_unknown  <= RST_COLOR_UNKNOWN;
      color_free     <= RST_COLOR_FREE;
      color_occupied <= RST_COLOR_OCCUPIED;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLOCK_SIZE:     block_size     <= cfg_data[MAG_W-1:0];
        REG_MAP_WIDTH:      map_width      <= cfg_data[MAP_W-1:0];
        REG_MAP_HEIGHT:     map_height     <= cfg_data[MAP_W-1:0];
        REG_COLOR_UNKNOWN:  color_unknown  <= cfg_data;
        REG_COLOR_FREE:     color_free     <= cfg_data;
        REG_COLOR_OCCUPIED: color_occupied <= cfg_data;
        default: ;
      endcase
    end
  end

  // Out-of-range sizes are pulled into range: zero acts as one, and anything above the
  // limit acts as the limit.
  always_comb begin
    if (block_size == '0) begin
      mag = MAG_W'(1);
    end else if (block_size > MAG_W'(BLOCK_MAX)) begin
      mag = MAG_W'(BLOCK_MAX);
    end else begin
      mag = block_size;
    end
    if (map_width == '0) begin
      w_c = MAP_W'(1);
    end else if (map_width > MAP_W'(MAP_LIMIT)) begin
      w_c = MAP_W'(MAP_LIMIT);
    end else begin
      w_c = map_width;
    end
    if (map_height == '0) begin
      h_c = MAP_W'(1);
    end else if (map_height > MAP_W'(MAP_LIMIT)) begin
      h_c = MAP_W'(MAP_LIMIT);
    end else begin
      h_c = map_height;
    end
  end

  assign mag_m1 = BIDX_W'(mag - MAG_W'(1));
  assign w_m1   = CELL_W'(w_c - MAP_W'(1));
  assign h_m1   = CELL_W'(h_c - MAP_W'(1));

  // The output image size is recomputed the cycle after any write that can change it, and
  // once out of reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_go <= 1'b1;
    end else begin
      div_go <= cfg_write && (cfg_index == REG_BLOCK_SIZE || cfg_index == REG_MAP_WIDTH ||
                              cfg_index == REG_MAP_HEIGHT);
    end
  end

  ompd_div u_div_cols (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (w_c),
    .divisor  (mag),
    .busy     (busy_c),
    .quotient (cols_q)
  );

  ompd_div u_div_rows (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (h_c),
    .divisor  (mag),
    .busy     (busy_r),
    .quotient (rows_q)
  );

  // The line store holds at most OUT_WIDTH_MAX pixels; later squares of the row are dropped.
  assign cols_lim = (cols_q > MAP_W'(OUT_WIDTH_MAX)) ? OCOL_W'(OUT_WIDTH_MAX)
                                                     : cols_q[OCOL_W-1:0];

  // ------------------------------------------------------------------
  // Input handshake. A new cell is taken only when the queue is sure to have room for the
  // pixel it may produce, counting the one still in the merge stage.
  // ------------------------------------------------------------------
  assign q_demand  = {1'b0, q_count} + {2'b00, s1_valid && s1_q.emit};
  assign in_stall  = div_go || busy_c || busy_r || (q_demand >= 3'd3);
  assign in_accept = in_valid && !in_stall;

  // ------------------------------------------------------------------
  // Accept stage: position bookkeeping and the running minimum along a square's row.
  // ------------------------------------------------------------------
  assign last_col  = (col_in_blk >= mag_m1);
  assign last_row  = (row_in_blk >= mag_m1);
  assign row_end   = (cell_col >= w_m1);
  assign frame_end = (cell_row >= h_m1);
  assign in_range  = (out_col < cols_lim) && (out_row < rows_q);

  always_comb begin
    known      = 1'b1;
    cell_color = color_unknown;
    case (cell_req)
      CELL_UNKNOWN:  cell_color = color_unknown;
      CELL_FREE:     cell_color = color_free;
      CELL_OCCUPIED: cell_color = color_occupied;
      default:       known      = 1'b0;
    endcase
  end

  assign run_upd = (in_range && known && (cell_color < run_min)) ? cell_color : run_min;

  // The merge stage of the previous cell may be writing the very entry this cell reads; the
  // read then returns the old word, so the fresh value is carried along instead.
  always_comb begin
    s1_next.wr        = in_range && last_col;
    s1_next.emit      = in_range && last_col && last_row;
    s1_next.use_store = (row_in_blk != '0);
    s1_next.fwd       = s1_valid && s1_q.wr && (s1_q.addr == out_col[ADDR_W-1:0]);
    s1_next.fwd_data  = merged;
    s1_next.partial   = run_upd;
    s1_next.addr      = out_col[ADDR_W-1:0];
    s1_next.y         = out_row[PIX_Y_W-1:0];
    s1_next.last      = (out_col + OCOL_W'(1) == cols_lim) && (out_row + OROW_W'(1) == rows_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_q <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min    <= RST_COLOR_UNKNOWN;
      cell_col   <= '0;
      cell_row   <= '0;
      col_in_blk <= '0;
      row_in_blk <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else if (in_accept) begin
      if (row_end) begin
        // End of an input row: every horizontal count starts again.
        cell_col   <= '0;
        col_in_blk <= '0;
        out_col    <= '0;
        run_min    <= color_unknown;
        if (frame_end) begin
          cell_row   <= '0;
          row_in_blk <= '0;
          out_row    <= '0;
        end else begin
          cell_row <= cell_row + CELL_W'(1);
          if (last_row) begin
            row_in_blk <= '0;
            if (out_row < rows_q) begin
              out_row <= out_row + OROW_W'(1);
            end
          end else begin
            row_in_blk <= row_in_blk + BIDX_W'(1);
          end
        end
      end else begin
        cell_col   <= cell_col + CELL_W'(1);
        col_in_blk <= last_col ? '0 : col_in_blk + BIDX_W'(1);
        if (in_range && last_col) begin
          out_col <= out_col + OCOL_W'(1);
          run_min <= color_unknown;
        end else begin
          run_min <= run_upd;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Merge stage: fold in the minimum of the rows above in this square and write it back.
  // The line store is read as the cell is accepted, so its data lands here.
  // ------------------------------------------------------------------
  ompd_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (OUT_WIDTH_MAX)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_q.addr),
    .wdata (merged),
    .re    (in_accept),
    .raddr (out_col[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign store_val = s1_q.fwd ? s1_q.fwd_data : ram_rdata;
  assign merged    = (s1_q.use_store && (store_val < s1_q.partial)) ? store_val : s1_q.partial;
  assign ram_we    = s1_valid && s1_q.wr;

  // ------------------------------------------------------------------
  // Output queue.
  // ------------------------------------------------------------------
  assign push           = s1_valid && s1_q.emit;
  assign push_item.pixel = merged;
  assign push_item.x     = s1_q.addr;
  assign push_item.y     = s1_q.y;
  assign push_item.last  = s1_q.last;
  assign pop            = out_valid && !out_stall;

  ompd_fifo u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (out_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  assign pixel      = head_item.pixel;
  assign pixel_x    = head_item.x;
  assign pixel_y    = head_item.y;
  assign frame_last = head_item.last;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------
  // A pixel is only produced by a transaction that also updates the line store.
  a_emit_writes: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_q.emit) |-> s1_q.wr)
    else $error("pixel produced without a line store write");

  // Forwarding is only chosen when the previous cell really wrote the store.
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_q.fwd) |-> $past(s1_valid && s1_q.wr))
    else $error("forwarded data without a preceding write");

  // The line store is only written inside the output row.
  a_store_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_q.wr) |-> ({1'b0, s1_q.addr} < cols_lim))
    else $error("line store written beyond the output row");

  // No cell is taken while the output size is being worked out.
  a_size_ready: assert property (@(posedge clk) disable iff (rst)
    (busy_c || busy_r) |-> !in_accept)
    else $error("cell accepted during size computation");

endmodule
